### hw/rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants for the streaming 3x3 box filter.
// ----------------------------------------------------------------------------
package bb3_pkg;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam int CFG_DATA_BITS   = 13;
	localparam int HEIGHT_LIMIT    = 4096;
	localparam int VALUE_BITS      = 16;
	localparam int COLUMN_BITS     = 8;
	localparam int ROW_BITS        = 12;

	// result queue
	localparam int FIFO_DEPTH      = 16;
	localparam int FIFO_PTR_BITS   = 4;
	localparam int FIFO_CNT_BITS   = 5;

	typedef struct packed {
		logic [VALUE_BITS-1:0]  value;
		logic [COLUMN_BITS-1:0] column;
		logic [ROW_BITS-1:0]    row;
		logic                   last;
	} result_t;

endpackage

### hw/rtl/box_blur_3x3_stream.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream
// Streaming 3x3 box filter with two line stores and a column-sum window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_valid/in_ready channel, one per
// transfer. Interior pixel (r,c) leaves as floor(sum of 3x3 / 9) once pixel
// (r+1,c+1) has come in; border pixels leave unchanged on the transfer that
// brings them. Each result carries its column and row, and last_of_run marks
// the final result caused by one input (zero, one or two results per input).
// Image size is set through cfg_write/cfg_index/cfg_data; any write restarts
// the image at row 0, column 0 and keeps the line store contents.
// Throughput: one pixel per cycle while in_ready is high; each line store
// takes one read and one write a cycle, and the datapath has three stages
// (line store read, column sum, window sum and reciprocal multiply). Results
// queue in a 16-entry buffer. On the last row of an image every input from
// column 2 on makes two results, so once the buffer fills, input there is
// limited to one pixel per two results taken out. in_ready drops only when
// the buffer cannot take the worst case of all pixels in flight; a stalled
// receiver therefore stops input with nothing lost. Reset clears counters,
// pipeline and buffer, and sets width and height to 256; line stores need no
// clearing.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream #(
	parameter int MAX_WIDTH  = 256,
	parameter int PIXEL_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic                               cfg_index,
	input  logic [bb3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bb3_pkg::VALUE_BITS-1:0]     pixel_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bb3_pkg::VALUE_BITS-1:0]     blurred_value,
	output logic [bb3_pkg::COLUMN_BITS-1:0]    out_column,
	output logic [bb3_pkg::ROW_BITS-1:0]       out_row,
	output logic                               last_of_run
);

	localparam int PW   = (PIXEL_BITS < bb3_pkg::VALUE_BITS) ? PIXEL_BITS : bb3_pkg::VALUE_BITS;
	localparam int CW   = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
	localparam int CSW  = PW + 2;
	localparam int SW   = PW + 4;
	localparam int K    = SW + 3;
	localparam int MW   = K - 2;
	localparam int PRW  = SW + MW;
	localparam longint RECIP_VAL = ((64'd1 << K) + 64'd8) / 64'd9;
	localparam logic [MW-1:0] RECIP = MW'(RECIP_VAL);
	localparam int RST_WIDTH = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam logic [CW-1:0] RST_LAST_COL = CW'(RST_WIDTH - 1);
	localparam logic [bb3_pkg::ROW_BITS-1:0] RST_LAST_ROW = bb3_pkg::ROW_BITS'(255);
	localparam int RW = bb3_pkg::ROW_BITS;

	// configuration and position
	logic [CW-1:0] last_col_q, new_last_col, col_q;
	logic [RW-1:0] last_row_q, new_last_row, row_q;
	logic [8:0]    wv;
	logic [12:0]   hv;
	logic          accept;

	// line stores
	logic [PW-1:0] older_mem [MAX_WIDTH];
	logic [PW-1:0] prev_mem  [MAX_WIDTH];

	// pipeline
	logic          v_s1, v_s2, v_s3;
	logic [PW-1:0] pix_s1, pix_s2, pix_s3;
	logic [PW-1:0] top_s1, mid_s1;
	logic [CW-1:0] col_s1, col_s2, col_s3;
	logic [RW-1:0] row_s1, row_s2, row_s3;
	logic          interior_s2, interior_s3, border_s2, border_s3;
	logic [CSW-1:0] colsum_s2, cs1_q, cs2_q;
	logic [SW-1:0] sum_s3;
	logic [PRW-1:0] prod;
	logic [PW-1:0] quot;

	// result queue
	bb3_pkg::result_t fifo_q [bb3_pkg::FIFO_DEPTH];
	bb3_pkg::result_t e0, e1, head;
	logic [bb3_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [bb3_pkg::FIFO_CNT_BITS-1:0] count_q;
	logic [1:0]    n_wr;
	logic          pop;
	logic [5:0]    reserve;
	logic [31:0]   col_ext, colm_ext;

	assign accept = in_valid && in_ready;
	assign pop    = out_valid && out_ready;

	// clamp the written size to the usable range
	always_comb begin
		wv = cfg_data[8:0];
		hv = cfg_data[12:0];
		if (wv < 9'd3) begin
			new_last_col = CW'(2);
		end else if (32'(wv) > MAX_WIDTH) begin
			new_last_col = CW'(MAX_WIDTH - 1);
		end else begin
			new_last_col = CW'(wv - 9'd1);
		end
		if (hv < 13'd3) begin
			new_last_row = RW'(2);
		end else if (32'(hv) > bb3_pkg::HEIGHT_LIMIT) begin
			new_last_row = RW'(bb3_pkg::HEIGHT_LIMIT - 1);
		end else begin
			new_last_row = RW'(hv - 13'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= RST_LAST_COL;
			last_row_q <= RST_LAST_ROW;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				bb3_pkg::REG_IMAGE_WIDTH:  last_col_q <= new_last_col;
				bb3_pkg::REG_IMAGE_HEIGHT: last_row_q <= new_last_row;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line stores: read on the input transfer, write back in the following cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= older_mem[col_q];
			mid_s1 <= prev_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			older_mem[col_s1] <= mid_s1;
			prev_mem[col_s1]  <= pix_s1;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// pipeline payload and column-sum window
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel_value[PW-1:0];
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
		if (v_s1) begin
			colsum_s2   <= CSW'(top_s1) + CSW'(mid_s1) + CSW'(pix_s1);
			pix_s2      <= pix_s1;
			col_s2      <= col_s1;
			row_s2      <= row_s1;
			interior_s2 <= (row_s1 >= RW'(2)) && (col_s1 >= CW'(2));
			border_s2   <= (row_s1 == '0) || (row_s1 == last_row_q) ||
			               (col_s1 == '0) || (col_s1 == last_col_q);
		end
		if (v_s2) begin
			sum_s3      <= SW'(colsum_s2) + SW'(cs1_q) + SW'(cs2_q);
			cs1_q       <= colsum_s2;
			cs2_q       <= cs1_q;
			pix_s3      <= pix_s2;
			col_s3      <= col_s2;
			row_s3      <= row_s2;
			interior_s3 <= interior_s2;
			border_s3   <= border_s2;
		end
	end

	// divide by nine through the reciprocal
	always_comb begin
		prod     = PRW'(sum_s3) * PRW'(RECIP);
		quot     = PW'(prod >> K);
		col_ext  = 32'(col_s3);
		colm_ext = 32'(col_s3 - CW'(1));
		e0       = '0;
		e1       = '0;
		n_wr     = 2'd0;
		if (v_s3) begin
			n_wr = {1'b0, interior_s3} + {1'b0, border_s3};
		end
		if (interior_s3) begin
			e0.value  = bb3_pkg::VALUE_BITS'(quot);
			e0.column = colm_ext[bb3_pkg::COLUMN_BITS-1:0];
			e0.row    = row_s3 - RW'(1);
			e0.last   = !border_s3;
			e1.value  = bb3_pkg::VALUE_BITS'(pix_s3);
			e1.column = col_ext[bb3_pkg::COLUMN_BITS-1:0];
			e1.row    = row_s3;
			e1.last   = 1'b1;
		end else begin
			e0.value  = bb3_pkg::VALUE_BITS'(pix_s3);
			e0.column = col_ext[bb3_pkg::COLUMN_BITS-1:0];
			e0.row    = row_s3;
			e0.last   = 1'b1;
		end
	end

	// keep room for two results per pixel in flight
	assign reserve  = 6'(count_q) + 6'({v_s1, 1'b0}) + 6'({v_s2, 1'b0}) +
	                  6'({v_s3, 1'b0}) + 6'd2;
	assign in_ready = (reserve <= 6'(bb3_pkg::FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			fifo_q[wr_ptr_q] <= e0;
		end
		if (n_wr == 2'd2) begin
			fifo_q[wr_ptr_q + bb3_pkg::FIFO_PTR_BITS'(1)] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + bb3_pkg::FIFO_PTR_BITS'(n_wr);
			rd_ptr_q <= rd_ptr_q + bb3_pkg::FIFO_PTR_BITS'(pop);
			count_q  <= count_q + bb3_pkg::FIFO_CNT_BITS'(n_wr)
			            - bb3_pkg::FIFO_CNT_BITS'(pop);
		end
	end

	assign head          = fifo_q[rd_ptr_q];
	assign out_valid     = (count_q != '0);
	assign blurred_value = head.value;
	assign out_column    = head.column;
	assign out_row       = head.row;
	assign last_of_run   = head.last;

	// checks
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bb3_pkg::FIFO_CNT_BITS'(bb3_pkg::FIFO_DEPTH))
		else $error("result queue over its depth");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col_q)
		else $error("column counter beyond image width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= last_row_q)
		else $error("row counter beyond image height");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && col_q == last_col_q) |=> (col_q == '0))
		else $error("column did not wrap at row end");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		(n_wr != 2'd0) |-> (6'(count_q) + 6'(n_wr) <= 6'(bb3_pkg::FIFO_DEPTH)))
		else $error("results written without room");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming 3x3 box filter.
// ----------------------------------------------------------------------------
// Pixels go in over valid/ready with random gaps. Each accepted pixel runs
// through a bench-side copy of the line stores, window and counters, which
// queues the results it must cause. Every result transfer is checked field by
// field against the oldest queued result. Image size is changed only while
// the filter is idle. Sizes cover the clamped extremes, a full-width row,
// a long receiver hold-off and a run of random images.
// ----------------------------------------------------------------------------
module tb;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_write = 1'b0;
	logic                              cfg_index = bb3_pkg::REG_IMAGE_WIDTH;
	logic [bb3_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [bb3_pkg::VALUE_BITS-1:0]    pixel_value = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [bb3_pkg::VALUE_BITS-1:0]    blurred_value;
	logic [bb3_pkg::COLUMN_BITS-1:0]   out_column;
	logic [bb3_pkg::ROW_BITS-1:0]      out_row;
	logic                              last_of_run;

	// bench copy of the filter state
	logic [15:0]  row_above     [0:255] = '{default: '0};
	logic [15:0]  row_two_above [0:255] = '{default: '0};
	logic [15:0]  window_cols   [0:5]   = '{default: '0};
	logic [8:0]   width_setting  = 9'd256;
	logic [12:0]  height_setting = 13'd256;
	int unsigned  pix_col = 0;
	int unsigned  pix_row = 0;

	bb3_pkg::result_t pending_blur_results [$];
	int unsigned  mismatch_count = 0;

	bit           source_gaps = 1'b1;
	bit           sink_gaps = 1'b1;
	int unsigned  sink_hold_cycles = 0;

	box_blur_3x3_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_value   (pixel_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blurred_value (blurred_value),
		.out_column    (out_column),
		.out_row       (out_row),
		.last_of_run   (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned effective_width();
		if (width_setting < 3)
			return 3;
		if (width_setting > 256)
			return 256;
		return 32'(width_setting);
	endfunction

	function automatic int unsigned effective_height();
		if (height_setting < 3)
			return 3;
		if (height_setting > bb3_pkg::HEIGHT_LIMIT)
			return bb3_pkg::HEIGHT_LIMIT;
		return 32'(height_setting);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(16'hFFFF - $urandom_range(0, 15));
			default: return 16'($urandom());
		endcase
	endfunction

	// one accepted pixel: queue the results it causes and advance the state
	function automatic void predict_box_blur(input logic [15:0] px);
		int unsigned w, h, c, r;
		logic [7:0]  ci;
		logic [15:0] up_two, up_one;
		logic [19:0] total;
		bit          interior, border;
		bb3_pkg::result_t item;
		w = effective_width();
		h = effective_height();
		c = pix_col;
		r = pix_row;
		if (c >= w)
			c = w - 1;
		if (r >= h)
			r = h - 1;
		ci = 8'(c);
		up_two = row_two_above[ci];
		up_one = row_above[ci];
		interior = (r >= 2) && (c >= 2);
		border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
		if (interior) begin
			total = 20'(up_two) + 20'(up_one) + 20'(px) +
				20'(window_cols[0]) + 20'(window_cols[1]) + 20'(window_cols[2]) +
				20'(window_cols[3]) + 20'(window_cols[4]) + 20'(window_cols[5]);
			item.value = 16'(total / 9);
			item.column = 8'(c - 1);
			item.row = 12'(r - 1);
			item.last = !border;
			pending_blur_results = {pending_blur_results, item};
		end
		if (border) begin
			item.value = px;
			item.column = 8'(c);
			item.row = 12'(r);
			item.last = 1'b1;
			pending_blur_results = {pending_blur_results, item};
		end
		window_cols[3] = window_cols[0];
		window_cols[4] = window_cols[1];
		window_cols[5] = window_cols[2];
		window_cols[0] = up_two;
		window_cols[1] = up_one;
		window_cols[2] = px;
		row_two_above[ci] = up_one;
		row_above[ci] = px;
		if (c + 1 >= w) begin
			pix_col = 0;
			pix_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			pix_col = c + 1;
			pix_row = r;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready === 1'b1)
			predict_box_blur(pixel_value);
	end

	always @(posedge clk) begin : result_check
		bb3_pkg::result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_blur_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result value %h col %0d row %0d last %b",
					$time, blurred_value, out_column, out_row, last_of_run);
			end else begin
				want = pending_blur_results.pop_front();
				if (blurred_value !== want.value || out_column !== want.column ||
						out_row !== want.row || last_of_run !== want.last) begin
					mismatch_count++;
					$display("%0t: mismatch expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
						$time, want.value, want.column, want.row, want.last,
						blurred_value, out_column, out_row, last_of_run);
				end
			end
		end
	end

	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold_cycles) @(posedge clk);
				sink_hold_cycles = 0;
				out_ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				stall = pick_gap() + 1;
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// valid stays up across back-to-back transfers; in_ready is settled by the falling edge
	task automatic send_pixel(input logic [15:0] px);
		int unsigned gap;
		gap = source_gaps ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= px;
		do
			@(negedge clk);
		while (in_ready !== 1'b1);
		@(posedge clk);
	endtask

	task automatic send_pixels(input int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++)
			send_pixel(pick_pixel());
	endtask

	// sender stops until every queued result is out, then the pipeline empties
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_blur_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic index, input int unsigned data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= bb3_pkg::CFG_DATA_BITS'(data);
		@(posedge clk);
		cfg_write <= 1'b0;
		if (index == bb3_pkg::REG_IMAGE_WIDTH)
			width_setting = 9'(data);
		else
			height_setting = 13'(data);
		// any write restarts the image, stores are kept
		pix_col = 0;
		pix_row = 0;
	endtask

	task automatic configure(input int unsigned width, input int unsigned height);
		wait_drained();
		if ($urandom_range(0, 1)) begin
			write_register(bb3_pkg::REG_IMAGE_WIDTH, width);
			write_register(bb3_pkg::REG_IMAGE_HEIGHT, height);
		end else begin
			write_register(bb3_pkg::REG_IMAGE_HEIGHT, height);
			write_register(bb3_pkg::REG_IMAGE_WIDTH, width);
		end
	endtask

	// reset sizes are 256 x 256, so a few pixels land in the top border row
	task automatic test_reset_sizes();
		send_pixels(6);
		wait_drained();
	endtask

	task automatic test_extreme_pixels();
		int unsigned i;
		configure(3, 3);
		// saturated image, the mean must come back at full scale
		for (i = 0; i < 9; i++)
			send_pixel(16'hFFFF);
		// checkerboard straight after, so the row count wraps without a write
		for (i = 0; i < 9; i++)
			send_pixel(i[0] ? 16'hFFFF : 16'h0000);
	endtask

	task automatic test_clamped_sizes();
		configure(0, 2);
		send_pixels(9);
		configure(1, 0);
		send_pixels(9);
		configure(2, 1);
		send_pixels(9);
		configure(3, 8191);
		send_pixels(9);
		configure(511, 4096);
		send_pixels(6);
	endtask

	// one whole row at the widest size, then the wrap into the next row
	task automatic test_full_width();
		configure(256, 3);
		send_pixels(258);
	endtask

	task automatic test_output_backpressure();
		configure(8, 6);
		source_gaps = 1'b0;
		sink_gaps = 1'b0;
		sink_hold_cycles = 120;
		send_pixels(30);
		wait_drained();
		source_gaps = 1'b1;
		sink_gaps = 1'b1;
		send_pixels(6);
	endtask

	task automatic test_random_images();
		int unsigned sent, w, h, count, i;
		sent = 0;
		while (sent < 20) begin
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(11, 511);
				default: w = $urandom_range(3, 10);
			endcase
			case ($urandom_range(0, 9))
				0: h = $urandom_range(0, 2);
				1: h = $urandom_range(7, 8191);
				default: h = $urandom_range(3, 6);
			endcase
			// a lone width write must also restart the image
			if ($urandom_range(0, 4) == 0) begin
				wait_drained();
				write_register(bb3_pkg::REG_IMAGE_WIDTH, w);
			end else begin
				configure(w, h);
			end
			source_gaps = $urandom_range(0, 3) != 0;
			sink_gaps = $urandom_range(0, 3) != 0;
			w = effective_width();
			h = effective_height();
			count = w * h * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0)
				count = $urandom_range(1, w * h);
			if (count > 15)
				count = $urandom_range(6, 15);
			for (i = 0; i < count; i++) begin
				send_pixel(pick_pixel());
				if ($urandom_range(0, 59) == 0)
					wait_drained();
			end
			sent += count;
		end
		source_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_sizes();
		test_extreme_pixels();
		test_clamped_sizes();
		test_full_width();
		test_output_backpressure();
		test_random_images();
		wait_drained();
		if (mismatch_count == 0 && pending_blur_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
